### hw/rtl/nlte_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package nlte_pkg;

    // Largest tab stop distance; tab_size above it saturates.
    localparam int MAX_TAB  = 32;
    localparam int PHASE_W  = (MAX_TAB > 1) ? $clog2(MAX_TAB) : 1;
    localparam int ETAB_W   = $clog2(MAX_TAB + 1);
    localparam int TABCFG_W = 6;

    // Command queue between classifier and emitter.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_SPACE = 8'd32;

    typedef enum logic [1:0] {
        STYLE_CR   = 2'd0,
        STYLE_LF   = 2'd1,
        STYLE_CRLF = 2'd2,
        STYLE_ANY  = 2'd3
    } t_style;

    typedef enum logic [1:0] {
        CFG_LINE_STYLE    = 2'd0,
        CFG_PRESERVE_TABS = 2'd1,
        CFG_TAB_SIZE      = 2'd2
    } t_cfg_idx;

    // Main action of one command; a CR prefix is a separate flag.
    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_CHAR = 2'd1,
        OP_TAB  = 2'd2,
        OP_NL   = 2'd3
    } t_op;

    typedef struct packed {
        logic       pre_cr;
        t_op        op;
        logic [7:0] ch;
    } t_cmd;

    // Effective tab size: zero reads as 1, large values saturate.
    function automatic logic [ETAB_W-1:0] eff_tab(input logic [TABCFG_W-1:0] tsz);
        logic [ETAB_W-1:0] t;
        if (tsz == '0) begin
            t = ETAB_W'(1);
        end else if (32'(tsz) > 32'(MAX_TAB)) begin
            t = ETAB_W'(MAX_TAB);
        end else begin
            t = ETAB_W'(tsz);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/nlte_front.sv
`timescale 1ns / 1ps
`default_nettype none

module nlte_front
    import nlte_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_end_of_input,
    input  wire t_style     i_line_style,
    input  wire logic       i_preserve_tabs,
    output t_cmd            o_cmd,
    output logic            o_push
);

    logic r_crp;
    logic r_ne;
    logic n_crp;
    logic n_ne;
    t_op  ap_op;
    t_cmd cmd;
    logic has;

    assign ap_op = (i_data_byte == CHAR_TAB && !i_preserve_tabs) ? OP_TAB : OP_CHAR;

    always_comb begin
        n_crp      = r_crp;
        n_ne       = r_ne;
        cmd.pre_cr = 1'b0;
        cmd.op     = OP_NONE;
        cmd.ch     = i_data_byte;
        if (i_end_of_input) begin
            cmd.pre_cr = (i_line_style == STYLE_CRLF) && r_crp;
            cmd.op     = (r_ne || cmd.pre_cr) ? OP_NL : OP_NONE;
            n_crp      = 1'b0;
        end else begin
            unique case (i_line_style)
                STYLE_CR: begin
                    n_crp  = 1'b0;
                    cmd.op = (i_data_byte == CHAR_CR) ? OP_NL : ap_op;
                end
                STYLE_LF: begin
                    n_crp  = 1'b0;
                    cmd.op = (i_data_byte == CHAR_LF) ? OP_NL : ap_op;
                end
                STYLE_CRLF: begin
                    n_crp = 1'b0;
                    if (r_crp && i_data_byte == CHAR_LF) begin
                        cmd.op = OP_NL;
                    end else begin
                        // held CR that was not followed by LF goes out as a char
                        cmd.pre_cr = r_crp;
                        if (i_data_byte == CHAR_CR) begin
                            n_crp = 1'b1;
                        end else begin
                            cmd.op = ap_op;
                        end
                    end
                end
                STYLE_ANY: begin
                    n_crp = 1'b0;
                    if (r_crp && i_data_byte == CHAR_LF) begin
                        cmd.op = OP_NONE;    // second half of CR LF
                    end else if (i_data_byte == CHAR_LF) begin
                        cmd.op = OP_NL;
                    end else if (i_data_byte == CHAR_CR) begin
                        cmd.op = OP_NL;
                        n_crp  = 1'b1;
                    end else begin
                        cmd.op = ap_op;
                    end
                end
                default: begin
                    cmd.op = OP_NONE;
                end
            endcase
        end
        has = cmd.pre_cr || (cmd.op != OP_NONE);
        if (i_end_of_input) begin
            n_ne = 1'b0;
        end else if (has) begin
            n_ne = (cmd.op != OP_NL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crp <= 1'b0;
            r_ne  <= 1'b0;
        end else if (i_accept) begin
            r_crp <= n_crp;
            r_ne  <= n_ne;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_accept && has;

    a_nl_clears_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && cmd.op == OP_NL) |=> !r_ne)
        else $error("line still marked non-empty after newline");

endmodule

`default_nettype wire

### hw/rtl/nlte_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module nlte_fifo
    import nlte_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output logic      o_head_valid,
    output logic      o_full
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (32'(p) == QDEPTH - 1) ? '0 : QPTR_W'(32'(p) + 1);
    endfunction

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (do_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    assign o_head       = r_mem[r_rptr];
    assign o_head_valid = (r_count != '0);
    assign o_full       = (32'(r_count) == QDEPTH);

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("pop from empty command queue");

endmodule

`default_nettype wire

### hw/rtl/nlte_back.sv
`timescale 1ns / 1ps
`default_nettype none

module nlte_back
    import nlte_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_head,
    input  wire logic              i_head_valid,
    output logic                   o_pop,
    input  wire logic [ETAB_W-1:0] i_tab_eff,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [7:0]             o_out_char,
    output logic                   o_newline,
    output logic                   o_last
);

    logic [PHASE_W-1:0] r_phase;
    logic [PHASE_W-1:0] n_phase;
    logic               r_pre_done;
    logic               n_pre_done;
    logic               r_ovalid;
    logic [7:0]         r_char;
    logic               r_nl;
    logic               r_last;

    logic [ETAB_W-1:0]  phase_ext;
    logic [ETAB_W-1:0]  inc;
    logic               wrap;
    logic [PHASE_W-1:0] phase_chr;
    logic               norm;
    logic               out_free;
    logic               emit;
    logic               pop;
    logic [7:0]         e_char;
    logic               e_nl;
    logic               e_last;
    logic               in_pre;

    assign phase_ext = ETAB_W'(r_phase);
    assign inc       = phase_ext + ETAB_W'(1);
    assign wrap      = (inc == i_tab_eff);
    assign phase_chr = wrap ? '0 : inc[PHASE_W-1:0];
    // stored phase may exceed a freshly written tab size: reduce it first
    assign norm      = (phase_ext >= i_tab_eff);
    assign out_free  = !r_ovalid || !i_stall;
    assign in_pre    = i_head.pre_cr && !r_pre_done;

    always_comb begin
        n_phase    = r_phase;
        n_pre_done = r_pre_done;
        emit       = 1'b0;
        pop        = 1'b0;
        e_char     = '0;
        e_nl       = 1'b0;
        e_last     = 1'b0;
        if (norm) begin
            n_phase = PHASE_W'(phase_ext - i_tab_eff);
        end else if (i_head_valid && out_free) begin
            emit = 1'b1;
            if (in_pre) begin
                e_char  = CHAR_CR;
                e_last  = (i_head.op == OP_NONE);
                n_phase = phase_chr;
                if (i_head.op == OP_NONE) begin
                    pop = 1'b1;
                end else begin
                    n_pre_done = 1'b1;
                end
            end else begin
                case (i_head.op)
                    OP_CHAR: begin
                        e_char  = i_head.ch;
                        e_last  = 1'b1;
                        n_phase = phase_chr;
                        pop     = 1'b1;
                    end
                    OP_TAB: begin
                        e_char  = CHAR_SPACE;
                        e_last  = wrap;
                        n_phase = phase_chr;
                        pop     = wrap;
                    end
                    OP_NL: begin
                        e_nl    = 1'b1;
                        e_last  = 1'b1;
                        n_phase = '0;
                        pop     = 1'b1;
                    end
                    default: begin
                        emit = 1'b0;
                        pop  = 1'b1;
                    end
                endcase
            end
            if (pop) begin
                n_pre_done = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= '0;
            r_pre_done <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pre_done <= n_pre_done;
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && emit) begin
            r_char <= e_char;
            r_nl   <= e_nl;
            r_last <= e_last;
        end
    end

    assign o_pop      = pop;
    assign o_valid    = r_ovalid;
    assign o_out_char = r_char;
    assign o_newline  = r_nl;
    assign o_last     = r_last;

    a_tab_ends_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !in_pre && i_head.op == OP_TAB) |=> (r_phase == '0))
        else $error("tab expansion did not end on a tab stop");

endmodule

`default_nettype wire

### hw/rtl/newline_normalize_tab_expand.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_stall       i_data_byte, i_end_of_input
// output    out        o_valid / i_stall       o_out_char, o_newline, o_last
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A byte is classified in the cycle it is taken and becomes one command in a
// two-entry queue; o_stall is high only while that queue is full.
// The emitter produces one result per cycle unless i_stall holds it: a plain
// byte or newline gives one result, a tab one space per result (up to the tab
// size), a held CR one more. After tab_size shrinks mid-line, the column phase
// is reduced by one subtraction per cycle before the next result.
// Synchronous active-low reset; it restores line_style 3, tab expansion on,
// tab size 8, and an empty line. The output register holds under i_stall.

module newline_normalize_tab_expand
    import nlte_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // input bytes
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [7:0]          i_data_byte,
    input  wire logic                i_end_of_input,
    // results
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic [7:0]               o_out_char,
    output logic                     o_newline,
    output logic                     o_last,
    // register writes
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [TABCFG_W-1:0] i_cfg_data
);

    t_style               r_line_style;
    logic                 r_preserve_tabs;
    logic [TABCFG_W-1:0]  r_tab_size;
    logic [ETAB_W-1:0]    tab_eff;

    logic                 accept;
    logic                 push;
    t_cmd                 cmd;
    t_cmd                 head;
    logic                 head_valid;
    logic                 pop;
    logic                 full;

    // Register file: always ready, one write per transfer.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_style    <= STYLE_ANY;
            r_preserve_tabs <= 1'b0;
            r_tab_size      <= TABCFG_W'(8);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LINE_STYLE:    r_line_style    <= t_style'(i_cfg_data[1:0]);
                CFG_PRESERVE_TABS: r_preserve_tabs <= i_cfg_data[0];
                CFG_TAB_SIZE:      r_tab_size      <= i_cfg_data;
                default: begin
                    // index beyond the register list: ignored
                end
            endcase
        end
    end

    assign tab_eff = eff_tab(r_tab_size);

    assign o_stall = full;
    assign accept  = i_valid && !full;

    // Front end: line-ending state and command build.
    nlte_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_data_byte),
        .i_end_of_input  (i_end_of_input),
        .i_line_style    (r_line_style),
        .i_preserve_tabs (r_preserve_tabs),
        .o_cmd           (cmd),
        .o_push          (push)
    );

    // Decouples byte intake from multi-cycle tab runs.
    nlte_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    // Back end: column tracking, tab expansion, output register.
    nlte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_tab_eff    (tab_eff),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_char   (o_out_char),
        .o_newline    (o_newline),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire

### bench/newline_normalize_tab_expand_test.sv
`timescale 1ns / 1ps

// Checks the line-ending normalizer with tab expansion against a predictor.
// Each byte transfer runs the predictor, which queues the characters and
// newline markers that byte should produce. A checker pops one entry per
// output transfer and compares char, newline and last.
module newline_normalize_tab_expand_test;
    import nlte_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 64;    // covers a 32-space tab plus phase reduction
    localparam int HOLD_CYCLES   = 150;   // long receiver hold-off
    localparam int STALL_LIMIT   = 3000;  // cycles without any transfer
    localparam int RANDOM_ITEMS  = 320;

    // Index 3 maps to no register; writes there must be ignored.
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        logic [7:0] ch;
        logic       nl;
        logic       last;
    } t_norm_result;

    // Block inputs, all known from time zero.
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic [7:0]          i_data_byte    = 8'd0;
    logic                i_end_of_input = 1'b0;
    logic                i_stall        = 1'b0;
    logic                i_cfg_valid    = 1'b0;
    logic [1:0]          i_cfg_index    = 2'd0;
    logic [TABCFG_W-1:0] i_cfg_data     = '0;

    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic       o_newline;
    logic       o_last;
    logic       o_cfg_ready;

    newline_normalize_tab_expand dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_data_byte    (i_data_byte),
        .i_end_of_input (i_end_of_input),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_newline      (o_newline),
        .o_last         (o_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor state: register copies plus the line tracking state.
    // ------------------------------------------------------------------
    t_style              cur_style     = STYLE_ANY;
    bit                  keep_tabs     = 1'b0;
    logic [TABCFG_W-1:0] tab_cfg       = TABCFG_W'(8);
    int                  col_phase     = 0;
    bit                  line_has_text = 1'b0;
    bit                  cr_held       = 1'b0;

    t_norm_result expected_chars[$];  // awaiting output transfers, oldest first
    t_norm_result step_buf[$];        // results of the byte being predicted

    int  items_sent   = 0;
    int  results_seen = 0;
    int  reg_writes   = 0;
    int  mismatches   = 0;
    int  idle_cycles  = 0;
    bit  calm         = 1'b0;  // no random gaps on either side while set
    bit  hold_req     = 1'b0;  // asks the receiver for one long hold-off
    int  stall_left   = 0;
    t_norm_result want_res;

    // Stop distance as the block sees it: zero means 1, above MAX_TAB clamps.
    function automatic int tab_span();
        if (tab_cfg == '0) return 1;
        if (int'(tab_cfg) > MAX_TAB) return MAX_TAB;
        return int'(tab_cfg);
    endfunction

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic put_text(input logic [7:0] c);
        int           span;
        t_norm_result res;
        span     = tab_span();
        res.ch   = c;
        res.nl   = 1'b0;
        res.last = 1'b0;
        step_buf.insert(step_buf.size(), res);
        col_phase     = ((col_phase % span) + 1) % span;
        line_has_text = 1'b1;
    endtask

    task automatic put_eol();
        t_norm_result res;
        res.ch   = 8'd0;
        res.nl   = 1'b1;
        res.last = 1'b0;
        step_buf.insert(step_buf.size(), res);
        col_phase     = 0;
        line_has_text = 1'b0;
    endtask

    // A tab fills to the next stop unless tabs pass through.
    task automatic append_char(input logic [7:0] c);
        int span;
        int fill;
        span = tab_span();
        if (c == CHAR_TAB && !keep_tabs) begin
            fill = span - (col_phase % span);
            repeat (fill) put_text(CHAR_SPACE);
        end else begin
            put_text(c);
        end
    endtask

    // Work out everything one accepted byte (or end marker) produces.
    task automatic normalize_byte(input logic [7:0] b, input logic eoi);
        bit done;
        done = 1'b0;
        step_buf.delete();
        if (eoi) begin
            // flush a held CR, close a non-empty line, then start a new file
            if (cur_style == STYLE_CRLF && cr_held) append_char(CHAR_CR);
            if (line_has_text) put_eol();
            cr_held       = 1'b0;
            col_phase     = 0;
            line_has_text = 1'b0;
        end else begin
            case (cur_style)
                STYLE_CR: begin
                    cr_held = 1'b0;
                    if (b == CHAR_CR) put_eol(); else append_char(b);
                end
                STYLE_LF: begin
                    cr_held = 1'b0;
                    if (b == CHAR_LF) put_eol(); else append_char(b);
                end
                STYLE_CRLF: begin
                    // held CR: LF completes the pair, anything else releases it
                    if (cr_held) begin
                        cr_held = 1'b0;
                        if (b == CHAR_LF) begin
                            put_eol();
                            done = 1'b1;
                        end else begin
                            append_char(CHAR_CR);
                        end
                    end
                    if (!done) begin
                        if (b == CHAR_CR) cr_held = 1'b1; else append_char(b);
                    end
                end
                default: begin
                    // mixed: CR ends the line at once and swallows one LF after it
                    if (cr_held) begin
                        cr_held = 1'b0;
                        if (b == CHAR_LF) done = 1'b1;
                    end
                    if (!done) begin
                        if (b == CHAR_LF) begin
                            put_eol();
                        end else if (b == CHAR_CR) begin
                            put_eol();
                            cr_held = 1'b1;
                        end else begin
                            append_char(b);
                        end
                    end
                end
            endcase
        end
        if (step_buf.size() > 0) step_buf[step_buf.size() - 1].last = 1'b1;
        foreach (step_buf[i]) expected_chars.insert(expected_chars.size(), step_buf[i]);
    endtask

    // ------------------------------------------------------------------
    // Reporting and checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 40)
            $display("ERROR result %0d: %s, got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
        mismatches++;
    endtask

    // Output side: one comparison per result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_chars.size() == 0) begin
                report_mismatch("result with nothing expected",
                                {o_newline, o_out_char}, 0);
            end else begin
                want_res = expected_chars.pop_front();
                if (o_out_char !== want_res.ch)
                    report_mismatch("out_char", o_out_char, want_res.ch);
                if (o_newline !== want_res.nl)
                    report_mismatch("newline", o_newline, want_res.nl);
                if (o_last !== want_res.last)
                    report_mismatch("last", o_last, want_res.last);
            end
        end
    end

    // Receiver: random stall gaps, or one long hold-off when asked.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            stall_left = HOLD_CYCLES - 1;
            i_stall    <= 1'b1;
        end else if (calm) begin
            i_stall <= 1'b0;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any transfer on any channel resets the count.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Offer one item, hold it until the transfer, then maybe idle.
    task automatic send_item(input logic [7:0] b, input logic eoi);
        int gap;
        i_valid        <= 1'b1;
        i_data_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
        normalize_byte(b, eoi);
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stop offering, wait for every expected result, then let the block settle
    // (held CRs and phase reduction produce no result but may still be in flight).
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_chars.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [TABCFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        reg_writes++;
        case (idx)
            CFG_LINE_STYLE:    cur_style = t_style'(val[1:0]);
            CFG_PRESERVE_TABS: keep_tabs = val[0];
            CFG_TAB_SIZE:      tab_cfg   = val;
            default: ;
        endcase
    endtask

    // Registers change only with the block idle; line state carries over.
    task automatic program_regs(input t_style style, input bit pres,
                                input logic [TABCFG_W-1:0] tsz);
        wait_drained();
        write_reg(CFG_SPARE_IDX, TABCFG_W'($urandom_range(0, 63)));
        write_reg(CFG_LINE_STYLE, TABCFG_W'(style));
        write_reg(CFG_PRESERVE_TABS, TABCFG_W'(pres));
        write_reg(CFG_TAB_SIZE, tsz);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 8'($urandom_range(32, 126));
        if (r < 80) return CHAR_TAB;
        return 8'($urandom_range(0, 255));
    endfunction

    // A line of random text, usually closed by the ending the style expects.
    task automatic send_line(input int len);
        int r;
        repeat (len) send_item(random_text_byte(), 1'b0);
        r = $urandom_range(0, 9);
        if (r == 0) return;  // left open
        if (r < 8) begin
            case (cur_style)
                STYLE_CR:   send_item(CHAR_CR, 1'b0);
                STYLE_LF:   send_item(CHAR_LF, 1'b0);
                STYLE_CRLF: begin
                    send_item(CHAR_CR, 1'b0);
                    send_item(CHAR_LF, 1'b0);
                end
                default: begin
                    if ($urandom_range(0, 2) != 0) send_item(CHAR_CR, 1'b0);
                    if ($urandom_range(0, 2) != 0) send_item(CHAR_LF, 1'b0);
                end
            endcase
        end else begin
            // broken endings: doubled CR, or CR then LF
            send_item(CHAR_CR, 1'b0);
            if (r == 8) send_item(CHAR_CR, 1'b0);
            else send_item(CHAR_LF, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset settings: byte extremes, a tab after two characters, end markers.
    task automatic test_reset_defaults();
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(CHAR_TAB, 1'b0);
        send_item(8'hA5, 1'b1);  // closes the line
        send_item(8'h5A, 1'b1);  // empty line: nothing
    endtask

    task automatic test_line_styles();
        // CR style with tabs passed through, oversize tab setting
        program_regs(STYLE_CR, 1'b1, TABCFG_W'(63));
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_TAB, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(8'h00, 1'b1);
        // LF style, tab size zero acts as 1
        program_regs(STYLE_LF, 1'b0, TABCFG_W'(0));
        send_item(CHAR_TAB, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        // CR LF pair: held CR, lone CR released, pair, CR before tab, CR at end
        program_regs(STYLE_CRLF, 1'b0, TABCFG_W'(MAX_TAB));
        send_item(8'h61, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_TAB, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(8'hFF, 1'b1);
        // mixed: CR LF counts once, a second LF is its own line
        program_regs(STYLE_ANY, 1'b0, TABCFG_W'(MAX_TAB + 1));
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(CHAR_LF, 1'b0);
        send_item(CHAR_CR, 1'b0);
        send_item(CHAR_CR, 1'b0);
    endtask

    // Settings changed in mid-line: tab size shrinks under a live phase,
    // and a style switch while a CR is pending.
    task automatic test_midline_changes();
        program_regs(STYLE_ANY, 1'b0, TABCFG_W'(MAX_TAB));
        send_item(8'h70, 1'b0);
        send_item(8'h71, 1'b0);
        send_item(8'h72, 1'b0);
        program_regs(STYLE_ANY, 1'b0, TABCFG_W'(2));
        send_item(CHAR_TAB, 1'b0);
        send_item(CHAR_CR, 1'b0);
        program_regs(STYLE_CRLF, 1'b0, TABCFG_W'(8));
        send_item(CHAR_LF, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering, so the block backs
    // up and stalls its input; then the sender waits for everything to drain.
    task automatic test_backpressure();
        program_regs(STYLE_ANY, 1'b0, TABCFG_W'(MAX_TAB));
        calm     = 1'b1;
        hold_req = 1'b1;
        repeat (6) begin
            send_item(8'h62, 1'b0);
            send_item(CHAR_TAB, 1'b0);
            send_item(CHAR_LF, 1'b0);
        end
        calm = 1'b0;
        wait_drained();
        repeat (4) send_item(random_text_byte(), 1'b0);
        send_item(8'h00, 1'b1);
    endtask

    // Random rounds: fresh settings (extremes often), a few lines, maybe an end.
    task automatic test_random_stream();
        int                  stop_at;
        logic [TABCFG_W-1:0] tsz;
        stop_at = items_sent + RANDOM_ITEMS;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0:       tsz = TABCFG_W'(0);
                1:       tsz = TABCFG_W'(1);
                2:       tsz = TABCFG_W'(MAX_TAB);
                3:       tsz = TABCFG_W'(MAX_TAB + 1);
                4:       tsz = TABCFG_W'(63);
                default: tsz = TABCFG_W'($urandom_range(1, 16));
            endcase
            program_regs(t_style'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), tsz);
            calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 6)) send_line($urandom_range(0, 12));
            if ($urandom_range(0, 2) != 0)
                send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_line_styles();
        test_midline_changes();
        test_backpressure();
        test_random_stream();

        wait_drained();
        $display("covered %0d input transfers, %0d result transfers, %0d register writes",
                 items_sent, results_seen, reg_writes);
        $display("all four line styles, tab sizes 0 to 63, tabs expanded and passed");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
hw/rtl/nlte_pkg.sv
hw/rtl/nlte_front.sv
hw/rtl/nlte_fifo.sv
hw/rtl/nlte_back.sv
hw/rtl/newline_normalize_tab_expand.sv
bench/newline_normalize_tab_expand_test.sv
